[design/wvhs_pkg.sv]
package wvhs_pkg;

    localparam int ANG_W        = 21;
    localparam int VEC_W        = 35;
    localparam int PROD_W       = 52;
    localparam int CORDIC_STEPS = 16;
    localparam int QUOT_W       = 24;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 21'sd205887;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 21'sd102944;
    localparam logic signed [16:0]      INV_GAIN    = 17'sd39797;
    localparam logic [15:0]             THRESH_RESET = 16'd26;
    localparam logic signed [16:0]      PROJ_MAX    = 17'sd65535;
    localparam logic signed [16:0]      PROJ_MIN    = -17'sd65536;
    localparam logic signed [23:0]      CURV_MAX    = 24'sd8388607;
    localparam logic signed [23:0]      CURV_MIN    = -24'sd8388608;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [47:0]        stamp;
    } meta_t;

    typedef struct packed {
        logic [15:0]        spd;
        logic signed [16:0] tan;
        logic               neg;
        logic               do_div;
        logic               ovf;
    } tail_t;

    function automatic logic signed [ANG_W-1:0] atan_lut(input int unsigned idx);
        case (idx)
            0:       return 21'sd51472;
            1:       return 21'sd30386;
            2:       return 21'sd16055;
            3:       return 21'sd8150;
            4:       return 21'sd4091;
            5:       return 21'sd2047;
            6:       return 21'sd1024;
            7:       return 21'sd512;
            8:       return 21'sd256;
            9:       return 21'sd128;
            10:      return 21'sd64;
            11:      return 21'sd32;
            12:      return 21'sd16;
            13:      return 21'sd8;
            14:      return 21'sd4;
            default: return 21'sd2;
        endcase
    endfunction

    // gain-corrected product: round half up at bit 32, clamp to 17 bits
    function automatic logic signed [16:0] sat_proj(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] s;
        logic signed [20:0]     sh;
        s  = {p[PROD_W-1], p} + (53'sd1 <<< 31);
        sh = s[PROD_W:32];
        if (sh > 21'sd65535)
            return PROJ_MAX;
        else if (sh < -21'sd65536)
            return PROJ_MIN;
        else
            return sh[16:0];
    endfunction

endpackage

[design/wvhs_cordic_stage.sv]
module wvhs_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [wvhs_pkg::VEC_W-1:0]  x_in,
    input  logic signed [wvhs_pkg::VEC_W-1:0]  y_in,
    input  logic signed [wvhs_pkg::ANG_W-1:0]  z_in,
    output logic signed [wvhs_pkg::VEC_W-1:0]  x_out,
    output logic signed [wvhs_pkg::VEC_W-1:0]  y_out,
    output logic signed [wvhs_pkg::ANG_W-1:0]  z_out
);
    import wvhs_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = atan_lut(SHIFT);

    logic signed [VEC_W-1:0] dx, dy, x_next, y_next, x_reg, y_reg;
    logic signed [ANG_W-1:0] z_next, z_reg;

    assign dx = x_in >>> SHIFT;
    assign dy = y_in >>> SHIFT;

    always_comb
    begin
        if (z_in >= 0)
        begin
            x_next = x_in - dy;
            y_next = y_in + dx;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dy;
            y_next = y_in - dx;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[design/wvhs_sqrt_stage.sv]
module wvhs_sqrt_stage #(
    parameter int K = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [32:0] n_in,
    input  logic [32:0] r_in,
    output logic [32:0] n_out,
    output logic [32:0] r_out
);
    import wvhs_pkg::*;

    // one result bit per stage, test bit walks down by powers of four
    localparam logic [32:0] BIT = 33'd1 << (30 - 2 * K);

    logic [32:0] trial, n_next, r_next, n_reg, r_reg;

    assign trial = r_in + BIT;

    always_comb
    begin
        if (n_in >= trial)
        begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;

endmodule

[design/wvhs_div_stage.sv]
module wvhs_div_stage (
    input  logic                          clk,
    input  logic                          en,
    input  logic [31:0]                   rem_in,
    input  logic [wvhs_pkg::QUOT_W-1:0]   q_in,
    input  logic [31:0]                   s2_in,
    output logic [31:0]                   rem_out,
    output logic [wvhs_pkg::QUOT_W-1:0]   q_out,
    output logic [31:0]                   s2_out
);
    import wvhs_pkg::*;

    logic [32:0]        t;
    logic [31:0]        rem_next, rem_reg, s2_reg;
    logic [QUOT_W-1:0]  q_next, q_reg;

    assign t = {rem_in, 1'b0};

    // restoring step; remainder stays below the divisor
    always_comb
    begin
        if (t >= {1'b0, s2_in})
        begin
            rem_next = 32'(t - {1'b0, s2_in});
            q_next   = {q_in[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = t[31:0];
            q_next   = {q_in[QUOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            s2_reg  <= s2_in;
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign s2_out  = s2_reg;

endmodule

[design/world_vectors_to_heading_state.sv]
// Streams vehicle state samples: speed = floor(sqrt(vx^2+vy^2)), acceleration projected
// on the heading tangent (16-step CORDIC), and curvature = normal acceleration * 2^24 /
// speed^2 (24-step restoring divider, saturated, zero at or below speed_threshold).
// Heading, position and stamp pass through. One beat is taken every cycle while the
// output is not held. The square root and CORDIC stages run side by side, followed by
// the divider stages. A held output stalls the whole pipe; nothing is dropped.
// speed_threshold resets to 26 and must be written only while the pipe is empty.
module world_vectors_to_heading_state (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] heading,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] acc_x,
    input  logic signed [15:0] acc_y,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [47:0]        stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] heading_out,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic [15:0]        speed,
    output logic signed [16:0] tangent_acc,
    output logic signed [23:0] curvature,
    output logic [47:0]        stamp_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        speed_threshold
);
    import wvhs_pkg::*;

    localparam int NS   = 46;
    localparam int SQ0  = 2;
    localparam int MUL  = SQ0 + CORDIC_STEPS;
    localparam int RND  = MUL + 1;
    localparam int FLG  = RND + 1;
    localparam int LAST = FLG + QUOT_W + 1;

    logic        adv;
    logic [15:0] thr_reg;
    logic        vld_reg [NS];
    meta_t       meta_reg [NS];

    assign adv       = !(vld_reg[LAST] && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESH_RESET;
        else if (cfg_valid)
            thr_reg <= speed_threshold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= '{heading: heading, pos_x: pos_x, pos_y: pos_y, stamp: stamp};
            for (int i = 1; i < NS; i++)
                meta_reg[i] <= meta_reg[i-1];
        end
    end

    // stage 0: squares, angle setup and half-turn fold
    logic signed [ANG_W-1:0] h_ext, z0_next, z0_reg, z1_reg;
    logic signed [VEC_W-1:0] ax, ay, x0_next, y0_next, x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [31:0]      vx2_next, vy2_next, vx2_reg, vy2_reg;
    logic [31:0]             n1_reg;

    assign h_ext    = ANG_W'(heading);
    assign ax       = {{(VEC_W-32){acc_x[15]}}, acc_x, 16'b0};
    assign ay       = {{(VEC_W-32){acc_y[15]}}, acc_y, 16'b0};
    assign vx2_next = 32'(vel_x) * 32'(vel_x);
    assign vy2_next = 32'(vel_y) * 32'(vel_y);

    always_comb
    begin
        z0_next = -(h_ext <<< 3);
        x0_next = ax;
        y0_next = ay;
        if (z0_next > ANG_HALF_PI)
        begin
            z0_next = z0_next - ANG_PI;
            x0_next = -ax;
            y0_next = -ay;
        end
        else if (z0_next < -ANG_HALF_PI)
        begin
            z0_next = z0_next + ANG_PI;
            x0_next = -ax;
            y0_next = -ay;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z0_reg  <= z0_next;
            x0_reg  <= x0_next;
            y0_reg  <= y0_next;
            vx2_reg <= vx2_next;
            vy2_reg <= vy2_next;
            n1_reg  <= $unsigned(vx2_reg) + $unsigned(vy2_reg);
            x1_reg  <= x0_reg;
            y1_reg  <= y0_reg;
            z1_reg  <= z0_reg;
        end
    end

    // stages 2..17: CORDIC and square root side by side
    logic signed [VEC_W-1:0] cx [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] cy [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] cz [CORDIC_STEPS+1];
    logic [32:0]             sn [CORDIC_STEPS+1];
    logic [32:0]             sr [CORDIC_STEPS+1];

    assign cx[0] = x1_reg;
    assign cy[0] = y1_reg;
    assign cz[0] = z1_reg;
    assign sn[0] = {1'b0, n1_reg};
    assign sr[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_rot
        wvhs_cordic_stage #(.SHIFT(k)) u_cordic (
            .clk   (clk),
            .en    (adv),
            .x_in  (cx[k]),
            .y_in  (cy[k]),
            .z_in  (cz[k]),
            .x_out (cx[k+1]),
            .y_out (cy[k+1]),
            .z_out (cz[k+1])
        );
        wvhs_sqrt_stage #(.K(k)) u_sqrt (
            .clk   (clk),
            .en    (adv),
            .n_in  (sn[k]),
            .r_in  (sr[k]),
            .n_out (sn[k+1]),
            .r_out (sr[k+1])
        );
    end

    // gain removal, rounding, sign/overflow flags
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic [31:0]              s2m_reg, s2r_reg, s2f_reg;
    logic [15:0]              spdm_reg, spdr_reg;
    logic signed [16:0]       tanr_reg, nrmr_reg;
    logic [16:0]              absn;
    tail_t                    tail_reg [FLG:LAST-1];
    logic [31:0]              rem0_reg;

    assign absn = nrmr_reg[16] ? 17'(-nrmr_reg) : 17'(nrmr_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg   <= PROD_W'(cx[CORDIC_STEPS]) * PROD_W'(INV_GAIN);
            py_reg   <= PROD_W'(cy[CORDIC_STEPS]) * PROD_W'(INV_GAIN);
            spdm_reg <= sr[CORDIC_STEPS][15:0];
            s2m_reg  <= 32'(sr[CORDIC_STEPS][15:0]) * 32'(sr[CORDIC_STEPS][15:0]);
            tanr_reg <= sat_proj(px_reg);
            nrmr_reg <= sat_proj(py_reg);
            spdr_reg <= spdm_reg;
            s2r_reg  <= s2m_reg;
            tail_reg[FLG] <= '{spd: spdr_reg, tan: tanr_reg, neg: nrmr_reg[16],
                               do_div: (spdr_reg > thr_reg),
                               ovf: ({15'b0, absn} >= s2r_reg)};
            rem0_reg <= {15'b0, absn};
            s2f_reg  <= s2r_reg;
            for (int i = FLG + 1; i < LAST; i++)
                tail_reg[i] <= tail_reg[i-1];
        end
    end

    // divider stages
    logic [31:0]       dr [QUOT_W+1];
    logic [QUOT_W-1:0] dq [QUOT_W+1];
    logic [31:0]       ds [QUOT_W+1];

    assign dr[0] = rem0_reg;
    assign dq[0] = '0;
    assign ds[0] = s2f_reg;

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        wvhs_div_stage u_div (
            .clk     (clk),
            .en      (adv),
            .rem_in  (dr[j]),
            .q_in    (dq[j]),
            .s2_in   (ds[j]),
            .rem_out (dr[j+1]),
            .q_out   (dq[j+1]),
            .s2_out  (ds[j+1])
        );
    end

    // output stage: sign, saturation and zero at low speed
    tail_t              tl;
    logic [QUOT_W-1:0]  q;
    logic signed [23:0] curv_next, curv_reg;
    logic [15:0]        spd_reg;
    logic signed [16:0] tan_reg;

    assign tl = tail_reg[LAST-1];
    assign q  = dq[QUOT_W];

    always_comb
    begin
        if (!tl.do_div)
            curv_next = '0;
        else if (tl.ovf || q[QUOT_W-1])
            curv_next = tl.neg ? CURV_MIN : CURV_MAX;
        else if (tl.neg)
            curv_next = 24'(-$signed(q));
        else
            curv_next = $signed(q);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            curv_reg <= curv_next;
            spd_reg  <= tl.spd;
            tan_reg  <= tl.tan;
        end
    end

    assign out_valid   = vld_reg[LAST];
    assign heading_out = meta_reg[LAST].heading;
    assign pos_x_out   = meta_reg[LAST].pos_x;
    assign pos_y_out   = meta_reg[LAST].pos_y;
    assign stamp_out   = meta_reg[LAST].stamp;
    assign speed       = spd_reg;
    assign tangent_acc = tan_reg;
    assign curvature   = curv_reg;

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("held output did not stall input");

    a_low_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (speed <= thr_reg) |-> curvature == 24'sd0)
        else $error("curvature nonzero at low speed");

    a_speed_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed <= 16'd46341)
        else $error("speed beyond magnitude bound");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(curvature))
        else $error("stalled result changed");

endmodule

[test/world_vectors_to_heading_state_tb.sv]
`timescale 1ns / 100ps

module world_vectors_to_heading_state_tb;
    import wvhs_pkg::*;

    typedef struct {
        logic signed [15:0] heading;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [47:0]        stamp;
    } sample_t;

    typedef struct {
        logic signed [15:0] heading;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        speed;
        logic signed [16:0] tangent_acc;
        logic signed [23:0] curvature;
        logic [47:0]        stamp;
    } heading_state_t;

    class heading_state_scoreboard;
        heading_state_t pending_states[$];
        logic [15:0]    speed_thresh;
        int             mismatches;

        function new();
            speed_thresh = THRESH_RESET;
            mismatches   = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // remove CORDIC gain, round half up at bit 32, clamp to 17 bits
        function longint gain_fix(longint v);
            longint p;
            p = (v * 39797 + (64'sd1 <<< 31)) >>> 32;
            if (p > 65535)
                p = 65535;
            else if (p < -65536)
                p = -65536;
            return p;
        endfunction

        function void note_sample(sample_t s);
            heading_state_t e;
            longint x, y, z, dx, dy, vx, vy, tn, nr, cv, s2;
            longint unsigned spd;
            vx  = longint'(s.vel_x);
            vy  = longint'(s.vel_y);
            x   = longint'(s.acc_x) * 65536;
            y   = longint'(s.acc_y) * 65536;
            z   = -(longint'(s.heading) * 8);
            spd = int_sqrt(vx * vx + vy * vy);
            if (z > 102944)
            begin
                z -= 205887;
                x = -x;
                y = -y;
            end
            else if (z < -102944)
            begin
                z += 205887;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = x >>> i;
                dy = y >>> i;
                if (z >= 0)
                begin
                    x -= dy;
                    y += dx;
                    z -= longint'(atan_lut(i));
                end
                else
                begin
                    x += dy;
                    y -= dx;
                    z += longint'(atan_lut(i));
                end
            end
            tn = gain_fix(x);
            nr = gain_fix(y);
            cv = 0;
            if (spd > speed_thresh)
            begin
                s2 = longint'(spd * spd);
                cv = (nr * 16777216) / s2;
                if (cv > 8388607)
                    cv = 8388607;
                else if (cv < -8388608)
                    cv = -8388608;
            end
            e.heading     = s.heading;
            e.pos_x       = s.pos_x;
            e.pos_y       = s.pos_y;
            e.speed       = spd[15:0];
            e.tangent_acc = tn[16:0];
            e.curvature   = cv[23:0];
            e.stamp       = s.stamp;
            pending_states.push_back(e);
        endfunction

        function void check_state(heading_state_t a);
            heading_state_t e;
            if (pending_states.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat at %0t", $realtime);
                return;
            end
            e = pending_states.pop_front();
            if (a.heading !== e.heading || a.pos_x !== e.pos_x || a.pos_y !== e.pos_y ||
                a.speed !== e.speed || a.tangent_acc !== e.tangent_acc ||
                a.curvature !== e.curvature || a.stamp !== e.stamp)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t", $realtime);
                    $display("  exp hd=%0d px=%0d py=%0d spd=%0d tan=%0d curv=%0d st=%0d",
                             e.heading, e.pos_x, e.pos_y, e.speed, e.tangent_acc,
                             e.curvature, e.stamp);
                    $display("  got hd=%0d px=%0d py=%0d spd=%0d tan=%0d curv=%0d st=%0d",
                             a.heading, a.pos_x, a.pos_y, a.speed, a.tangent_acc,
                             a.curvature, a.stamp);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] heading;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [47:0]        stamp;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] heading_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic [15:0]        speed;
    logic signed [16:0] tangent_acc;
    logic signed [23:0] curvature;
    logic [47:0]        stamp_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        speed_threshold;

    heading_state_scoreboard sb;
    int  cycle_count;
    int  hold_cycles;
    bit  no_idle;

    world_vectors_to_heading_state uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .heading(heading), .vel_x(vel_x), .vel_y(vel_y), .acc_x(acc_x), .acc_y(acc_y),
        .pos_x(pos_x), .pos_y(pos_y), .stamp(stamp),
        .out_valid(out_valid), .out_stall(out_stall),
        .heading_out(heading_out), .pos_x_out(pos_x_out), .pos_y_out(pos_y_out),
        .speed(speed), .tangent_acc(tangent_acc), .curvature(curvature),
        .stamp_out(stamp_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .speed_threshold(speed_threshold)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function int gap_len();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    always @(posedge clk)
    begin
        heading_state_t a;
        cycle_count <= cycle_count + 1;
        if (cycle_count > 300000)
        begin
            $display("FAILURE");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                a.heading     = heading_out;
                a.pos_x       = pos_x_out;
                a.pos_y       = pos_y_out;
                a.speed       = speed;
                a.tangent_acc = tangent_acc;
                a.curvature   = curvature;
                a.stamp       = stamp_out;
                sb.check_state(a);
            end
        end
    end

    // receiver: random stall, or a long hold-off when requested
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                n = gap_len();
                if (n == 0)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall <= 1'b1;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic send_sample(sample_t s);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        heading  <= s.heading;
        vel_x    <= s.vel_x;
        vel_y    <= s.vel_y;
        acc_x    <= s.acc_x;
        acc_y    <= s.acc_y;
        pos_x    <= s.pos_x;
        pos_y    <= s.pos_y;
        stamp    <= s.stamp;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_states.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        cfg_valid       <= 1'b1;
        speed_threshold <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.speed_thresh = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function sample_t rand_sample();
        sample_t s;
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            s.heading = 16'($urandom_range(0, 51472) - 25736);
        else
            s.heading = 16'($urandom);
        k = $urandom_range(0, 9);
        if (k < 5)
        begin
            s.vel_x = 16'($urandom_range(0, 4000) - 2000);
            s.vel_y = 16'($urandom_range(0, 4000) - 2000);
        end
        else if (k < 7)
        begin
            s.vel_x = 16'($urandom_range(0, 100) - 50);
            s.vel_y = 16'($urandom_range(0, 100) - 50);
        end
        else
        begin
            s.vel_x = 16'($urandom);
            s.vel_y = 16'($urandom);
        end
        s.acc_x = 16'($urandom);
        s.acc_y = 16'($urandom);
        if ($urandom_range(0, 1))
        begin
            s.acc_x = s.acc_x >>> 6;
            s.acc_y = s.acc_y >>> 6;
        end
        s.pos_x = $urandom;
        s.pos_y = $urandom;
        s.stamp = 48'({$urandom, $urandom});
        return s;
    endfunction

    function sample_t mk(int h, int vx, int vy, int ax, int ay);
        sample_t s;
        s.heading = 16'(h);
        s.vel_x   = 16'(vx);
        s.vel_y   = 16'(vy);
        s.acc_x   = 16'(ax);
        s.acc_y   = 16'(ay);
        s.pos_x   = $urandom;
        s.pos_y   = $urandom;
        s.stamp   = 48'({$urandom, $urandom});
        return s;
    endfunction

    initial
    begin
        sample_t s;
        logic [15:0] thr_list[5];
        sb          = new();
        cycle_count = 0;
        hold_cycles = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        heading     = '0;
        vel_x       = '0;
        vel_y       = '0;
        acc_x       = '0;
        acc_y       = '0;
        pos_x       = '0;
        pos_y       = '0;
        stamp       = '0;
        cfg_valid   = 1'b0;
        speed_threshold = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed, reset threshold first
        send_sample(mk(0, 0, 0, 0, 0));
        send_sample(mk(25736, 256, 0, 32767, 32767));
        send_sample(mk(-25736, 0, 256, -32768, -32768));
        send_sample(mk(32767, -32768, -32768, 32767, -32768));
        send_sample(mk(-32768, 32767, 32767, -32768, 32767));
        send_sample(mk(12868, 26, 0, 1000, -1000));
        send_sample(mk(-12868, 27, 0, 1000, -1000));
        send_sample(mk(0, 1, 1, 32767, 32767));
        send_sample(mk(0, -30, 2, -32768, -32768));
        send_sample(mk(6434, 1000, -1000, 500, 12));
        s = mk(0, 300, 0, 0, 256);
        s.pos_x = 32'sh7fffffff;
        s.pos_y = 32'sh80000000;
        s.stamp = 48'hffffffffffff;
        send_sample(s);
        s.pos_x = 32'sh80000000;
        s.pos_y = 32'sh7fffffff;
        s.stamp = '0;
        send_sample(s);
        drop_valid();
        wait_drained();
        write_threshold(16'd0);
        send_sample(mk(0, 1, 0, 0, 32767));
        send_sample(mk(0, 0, -1, 0, -32768));
        send_sample(mk(-25736, 1, 0, 0, 0));
        drop_valid();
        wait_drained();

        thr_list[0] = 16'd65535;
        thr_list[1] = 16'd26;
        thr_list[2] = 16'd0;
        thr_list[3] = 16'($urandom);
        thr_list[4] = 16'd512;
        for (int p = 0; p < 5; p++)
        begin
            write_threshold(thr_list[p]);
            no_idle = (p == 2);
            if (p == 1)
                hold_cycles = 300;
            for (int i = 0; i < 108; i++)
                send_sample(rand_sample());
            drop_valid();
            wait_drained();
        end

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
